>>> rtl/gb5_pkg.sv
// Package for the 5-tap line blur: tap register type, register indexes,
// reset weights and the pipeline control type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gb5_pkg;

    // Q0.16 tap weights
    localparam int TAP_BITS = 16;

    // configuration register indexes
    localparam logic [1:0] REG_OUTER  = 2'd0;
    localparam logic [1:0] REG_INNER  = 2'd1;
    localparam logic [1:0] REG_CENTER = 2'd2;

    // weights after reset (sigma of roughly 1.5)
    localparam logic [TAP_BITS-1:0] OUTER_RESET  = 16'd7871;
    localparam logic [TAP_BITS-1:0] INNER_RESET  = 16'd15329;
    localparam logic [TAP_BITS-1:0] CENTER_RESET = 16'd19209;

    // the three distinct weights of the symmetric kernel
    typedef struct packed {
        logic [TAP_BITS-1:0] outer_w;
        logic [TAP_BITS-1:0] inner_w;
        logic [TAP_BITS-1:0] center_w;
    } taps_t;

    // control that travels beside a filter job
    typedef struct packed {
        logic valid;
        logic last;
    } job_ctrl_t;

endpackage : gb5_pkg

`default_nettype wire

>>> rtl/gaussian_blur_5tap_line.sv
// Top level of the 5-tap line blur: tap registers, window sequencer, three
// colour lanes and the merge stage. Depends on gb5_pkg and all gb5_ modules.
//
//  channel   handshake              payload
//  pixel     pix_valid / pix_stall  red_in green_in blue_in line_end_in
//  result    res_valid / res_stall  red_out green_out blue_out line_end_out
//  config    cfg_valid / cfg_ready  cfg_index cfg_data
//
// One pixel per clock while the result is not stalled; a pixel that ends a
// line of two or more pixels holds the pixel channel while the right edge
// drains. A job passes the pre-add, multiply and output registers on its way
// to the result. A stalled result freezes the whole pipe.
// Reset clears the line position and the pipe; taps return to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_5tap_line
    import gb5_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    pix_valid,
    output logic                         pix_stall,
    input  wire logic [CHANNEL_BITS-1:0] red_in,
    input  wire logic [CHANNEL_BITS-1:0] green_in,
    input  wire logic [CHANNEL_BITS-1:0] blue_in,
    input  wire logic                    line_end_in,
    output logic                         res_valid,
    input  wire logic                    res_stall,
    output logic [CHANNEL_BITS-1:0]      red_out,
    output logic [CHANNEL_BITS-1:0]      green_out,
    output logic [CHANNEL_BITS-1:0]      blue_out,
    output logic                         line_end_out,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [TAP_BITS-1:0]     cfg_data
);

    taps_t taps_reg;
    logic  pipe_en;
    job_ctrl_t job;
    logic [2:0][CHANNEL_BITS-1:0] tap_a, tap_b, tap_c, tap_d, tap_e;
    logic [2:0][CHANNEL_BITS-1:0] lane_result;

    // tap registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg.outer_w  <= OUTER_RESET;
            taps_reg.inner_w  <= INNER_RESET;
            taps_reg.center_w <= CENTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OUTER:  taps_reg.outer_w  <= cfg_data;
                REG_INNER:  taps_reg.inner_w  <= cfg_data;
                REG_CENTER: taps_reg.center_w <= cfg_data;
                default:    ;
            endcase
        end
    end

    // window and edge sequencer
    gb5_window #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       ({blue_in, green_in, red_in}),
        .line_end  (line_end_in),
        .pipe_en   (pipe_en),
        .tap_a     (tap_a),
        .tap_b     (tap_b),
        .tap_c     (tap_c),
        .tap_d     (tap_d),
        .tap_e     (tap_e),
        .job       (job)
    );

    // one lane per colour channel
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        gb5_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .clk    (clk),
            .en     (pipe_en),
            .taps   (taps_reg),
            .a      (tap_a[ch]),
            .b      (tap_b[ch]),
            .c      (tap_c[ch]),
            .d      (tap_d[ch]),
            .e      (tap_e[ch]),
            .result (lane_result[ch])
        );
    end

    // output register and pipe enable
    gb5_merge #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .lane_result  (lane_result),
        .pipe_en      (pipe_en),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .line_end_out (line_end_out)
    );

endmodule : gaussian_blur_5tap_line

`default_nettype wire

>>> rtl/gb5_window.sv
// Pixel window and line sequencer: keeps the four previous pixels, clamps
// the edges and issues at most one filter job per cycle. Depends on gb5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gb5_window
    import gb5_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pix_valid,
    output logic                              pix_stall,
    input  wire logic [2:0][CHANNEL_BITS-1:0] pix,
    input  wire logic                         line_end,
    input  wire logic                         pipe_en,
    output logic [2:0][CHANNEL_BITS-1:0]      tap_a,
    output logic [2:0][CHANNEL_BITS-1:0]      tap_b,
    output logic [2:0][CHANNEL_BITS-1:0]      tap_c,
    output logic [2:0][CHANNEL_BITS-1:0]      tap_d,
    output logic [2:0][CHANNEL_BITS-1:0]      tap_e,
    output job_ctrl_t                         job
);

    localparam logic [1:0] POS_START = 2'd0;
    localparam logic [1:0] POS_FULL  = 2'd2;
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_LAST = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    logic [3:0][2:0][CHANNEL_BITS-1:0] win_reg, win_next;
    logic [2:0][CHANNEL_BITS-1:0]      hold_reg, hold_next;
    logic [1:0]                        pos_reg, pos_next;
    logic [1:0]                        pend_reg, pend_next;

    logic [3:0][2:0][CHANNEL_BITS-1:0] eff_win;
    logic [3:0][2:0][CHANNEL_BITS-1:0] src_win;
    logic [2:0][CHANNEL_BITS-1:0]      src_x;
    logic                              flushing;
    logic                              accept;

    // handshake: no new pixel while the line end is being drained
    assign flushing  = (pend_reg != PEND_NONE);
    assign pix_stall = !pipe_en || flushing;
    assign accept    = pix_valid && !pix_stall;

    // first pixel of a line fills the whole window (left edge clamp)
    assign eff_win = (pos_reg == POS_START) ? {4{pix}} : win_reg;
    assign src_win = flushing ? win_reg : eff_win;
    assign src_x   = flushing ? hold_reg : pix;

    // job taps, oldest first
    assign tap_a = src_win[3];
    assign tap_b = src_win[2];
    assign tap_c = src_win[1];
    assign tap_d = src_win[0];
    assign tap_e = src_x;

    // job issue and sequencer
    always_comb
    begin
        win_next   = win_reg;
        hold_next  = hold_reg;
        pos_next   = pos_reg;
        pend_next  = pend_reg;
        job.valid  = 1'b0;
        job.last   = 1'b0;
        if (flushing)
        begin
            // right edge: shift the held last pixel in once more per job
            job.valid = pipe_en;
            job.last  = (pend_reg == PEND_LAST);
            if (pipe_en)
            begin
                win_next  = {win_reg[2:0], hold_reg};
                pend_next = pend_reg - 2'd1;
            end
        end
        else if (accept)
        begin
            job.valid = (pos_reg == POS_FULL) || (line_end && (pos_reg == POS_START));
            job.last  = line_end && (pos_reg == POS_START);
            if (line_end)
            begin
                pos_next = POS_START;
                if (pos_reg != POS_START)
                begin
                    win_next  = {eff_win[2:0], pix};
                    hold_next = pix;
                    pend_next = PEND_TWO;
                end
            end
            else
            begin
                win_next = {eff_win[2:0], pix};
                if (pos_reg != POS_FULL)
                begin
                    pos_next = pos_reg + 2'd1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_START;
            pend_reg <= PEND_NONE;
        end
        else
        begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

    // pixel storage
    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        hold_reg <= hold_next;
    end

    // line end on a line of two or more pixels starts a two-job drain
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && line_end && (pos_reg != POS_START) |=> pend_reg == PEND_TWO)
        else $error("line end did not start the drain");

    // the drain only runs at the start of a fresh line
    a_drain_pos: assert property (@(posedge clk) disable iff (!rst_n)
        flushing |-> pos_reg == POS_START)
        else $error("line position not cleared during drain");

    // an issued last job leaves the sequencer at the start of a line
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid && job.last |=> pos_reg == POS_START && pend_reg == PEND_NONE)
        else $error("sequencer not back at line start after last job");

endmodule : gb5_window

`default_nettype wire

>>> rtl/gb5_lane.sv
// One colour lane of the blur: symmetric pre-add, three multiplies,
// sum, round and saturate. Depends on gb5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gb5_lane
    import gb5_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire taps_t                   taps,
    input  wire logic [CHANNEL_BITS-1:0] a,
    input  wire logic [CHANNEL_BITS-1:0] b,
    input  wire logic [CHANNEL_BITS-1:0] c,
    input  wire logic [CHANNEL_BITS-1:0] d,
    input  wire logic [CHANNEL_BITS-1:0] e,
    output logic [CHANNEL_BITS-1:0]      result
);

    localparam int SUM_W   = CHANNEL_BITS + 1;
    localparam int PROD_W  = SUM_W + TAP_BITS;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SCALE_W = ACC_W - TAP_BITS;
    localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) << (TAP_BITS - 1);
    localparam logic [SCALE_W-1:0] CHAN_MAX   = SCALE_W'({CHANNEL_BITS{1'b1}});

    logic [SUM_W-1:0]  outer_sum_reg, inner_sum_reg;
    logic [CHANNEL_BITS-1:0] center_reg;
    logic [PROD_W-1:0] outer_prod_reg, inner_prod_reg, center_prod_reg;
    logic [ACC_W-1:0]  acc;
    logic [SCALE_W-1:0] scaled;

    // stage 1: fold the symmetric taps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            outer_sum_reg <= SUM_W'(a) + SUM_W'(e);
            inner_sum_reg <= SUM_W'(b) + SUM_W'(d);
            center_reg    <= c;
        end
    end

    // stage 2: weight products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            outer_prod_reg  <= PROD_W'(outer_sum_reg) * PROD_W'(taps.outer_w);
            inner_prod_reg  <= PROD_W'(inner_sum_reg) * PROD_W'(taps.inner_w);
            center_prod_reg <= PROD_W'(center_reg) * PROD_W'(taps.center_w);
        end
    end

    // sum, round to nearest, drop the fraction and saturate
    assign acc    = ACC_W'(outer_prod_reg) + ACC_W'(inner_prod_reg)
                  + ACC_W'(center_prod_reg) + ROUND_HALF;
    assign scaled = acc[ACC_W-1:TAP_BITS];
    assign result = (scaled > CHAN_MAX) ? {CHANNEL_BITS{1'b1}} : scaled[CHANNEL_BITS-1:0];

endmodule : gb5_lane

`default_nettype wire

>>> rtl/gb5_merge.sv
// Merge stage: carries job control alongside the lanes, gathers the three
// lane results into the output register and drives the pipeline enable.
// Depends on gb5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gb5_merge
    import gb5_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire job_ctrl_t                    job,
    input  wire logic [2:0][CHANNEL_BITS-1:0] lane_result,
    output logic                              pipe_en,
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output logic [CHANNEL_BITS-1:0]           red_out,
    output logic [CHANNEL_BITS-1:0]           green_out,
    output logic [CHANNEL_BITS-1:0]           blue_out,
    output logic                              line_end_out
);

    job_ctrl_t ctrl1_reg, ctrl2_reg;
    logic      valid_reg;
    logic      last_reg;
    logic [2:0][CHANNEL_BITS-1:0] data_reg;

    // whole pipe moves unless a held transaction is being stalled
    assign pipe_en = !(valid_reg && res_stall);

    // control delay line matching the lane stages, plus output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            ctrl1_reg <= job;
            ctrl2_reg <= ctrl1_reg;
            valid_reg <= ctrl2_reg.valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            data_reg <= lane_result;
            last_reg <= ctrl2_reg.last;
        end
    end

    assign res_valid    = valid_reg;
    assign red_out      = data_reg[0];
    assign green_out    = data_reg[1];
    assign blue_out     = data_reg[2];
    assign line_end_out = last_reg;

endmodule : gb5_merge

`default_nettype wire
